// ----- design/sliding_window_median_assert.svh -----
// Assertion macros shared by the sliding window median design.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding_window_median: check failed");

// Next-cycle implication under the active-low reset.
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding_window_median: check failed");

`endif

// ----- design/swm_pkg.sv -----
`default_nettype none
package swm_pkg;

    localparam int CFG_BITS    = 13;
    localparam int SAMPLE_BITS = 16;
    localparam logic [CFG_BITS-1:0] WLEN_RESET = 13'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_SEL_START,
        S_SEL,
        S_PUSH
    } t_state;

endpackage
`default_nettype wire

// ----- design/sliding_window_median.sv -----
// A word is accepted only in S_IDLE and walked into the count tree one level a cycle.
// Once the window is full, S_SEL_START and S_SEL then select the median, S_PUSH
// registers it to the output (waiting while a held median is stalled), and a second
// walk takes the oldest word out. Reset is synchronous and active low; after it a
// clearing pass zeroes the count tree, and no word is accepted until it ends.
`default_nettype none
module sliding_window_median #(
    parameter int VALUE_BITS = 16,
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [swm_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  wire logic                              i_sample_valid,
    output logic                                   o_sample_stall,
    input  wire logic [swm_pkg::SAMPLE_BITS-1:0]   i_sample,
    output logic                                   o_median_valid,
    input  wire logic                              i_median_stall,
    output logic [swm_pkg::SAMPLE_BITS-1:0]        o_median
);
    import swm_pkg::*;

    localparam int AW  = VALUE_BITS + 1;
    localparam int CW  = CFG_BITS;
    localparam int PW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LVW = $clog2(VALUE_BITS + 2);

    logic [CW-1:0] tree_mem [2**AW];
    logic [VALUE_BITS-1:0] ring_mem [MAX_WINDOW];

    t_state r_state, n_state;
    logic [CW-1:0] r_wlen, r_fill, n_fill;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_clr, n_clr;
    logic [LVW-1:0] r_lvl, n_lvl;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic r_dec, n_dec, r_emit, n_emit;
    logic [AW-1:0] r_node, n_node;
    logic [CW-1:0] r_rank, n_rank;
    logic [VALUE_BITS-1:0] r_med, n_med;
    logic r_o_valid, n_o_valid;
    logic [SAMPLE_BITS-1:0] r_o_median, n_o_median;
    logic r_wpend, n_wpend;
    logic [AW-1:0] r_waddr;
    logic [CW-1:0] r_rdata;
    logic [VALUE_BITS-1:0] r_ring_q;

    logic [CW-1:0] k_eff;
    logic [PW-1:0] ptr_use;
    logic accept;
    logic rd_en, wr_en, ring_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [CW-1:0] wr_data;
    logic go_left;
    logic [AW-1:0] sel_node;

    function automatic logic [AW-1:0] node_at(input logic [VALUE_BITS-1:0] v,
                                              input logic [LVW-1:0] d);
        logic [AW-1:0] full;
        full = {1'b1, v};
        return full >> (VALUE_BITS - int'(d));
    endfunction

    always_comb begin
        k_eff = r_wlen;
        if (r_wlen == '0) begin
            k_eff = CW'(1);
        end else if (32'(r_wlen) > MAX_WINDOW) begin
            k_eff = CW'(MAX_WINDOW);
        end
    end

    assign ptr_use = (32'(r_ptr) >= 32'(k_eff)) ? '0 : r_ptr;
    assign accept = (r_state == S_IDLE) && i_sample_valid;
    assign go_left = (r_rank <= r_rdata);
    assign sel_node = {r_node[AW-2:0], ~go_left};

    always_comb begin
        n_state = r_state;
        n_fill = r_fill;
        n_ptr = r_ptr;
        n_clr = r_clr;
        n_lvl = r_lvl;
        n_val = r_val;
        n_dec = r_dec;
        n_emit = r_emit;
        n_node = r_node;
        n_rank = r_rank;
        n_med = r_med;
        n_o_median = r_o_median;
        n_o_valid = r_o_valid && i_median_stall;
        n_wpend = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_sample_valid) begin
                    n_val = VALUE_BITS'(i_sample);
                    n_dec = 1'b0;
                    n_lvl = '0;
                    n_ptr = (32'(ptr_use) + 1 >= 32'(k_eff)) ? '0 : ptr_use + PW'(1);
                    if (r_fill < k_eff) begin
                        n_fill = r_fill + CW'(1);
                    end
                    n_emit = (r_fill + CW'(1) >= k_eff);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_lvl = r_lvl + LVW'(1);
                n_wpend = (32'(r_lvl) <= VALUE_BITS);
                if (32'(r_lvl) == VALUE_BITS + 1) begin
                    n_state = (!r_dec && r_emit) ? S_SEL_START : S_IDLE;
                end
            end
            S_SEL_START: begin
                n_node = AW'(1);
                n_lvl = '0;
                n_rank = CW'((({1'b0, k_eff}) + (CW+1)'(1)) >> 1);
                n_state = S_SEL;
            end
            S_SEL: begin
                n_node = sel_node;
                n_lvl = r_lvl + LVW'(1);
                if (!go_left) begin
                    n_rank = r_rank - r_rdata;
                end
                if (32'(r_lvl) == VALUE_BITS - 1) begin
                    n_med = sel_node[VALUE_BITS-1:0];
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!r_o_valid || !i_median_stall) begin
                    n_o_valid = 1'b1;
                    n_o_median = SAMPLE_BITS'(r_med);
                    n_val = r_ring_q;
                    n_dec = 1'b1;
                    n_lvl = '0;
                    n_state = S_WALK;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = node_at(r_val, r_lvl);
        ring_rd = 1'b0;
        wr_en = r_wpend;
        wr_addr = r_waddr;
        wr_data = r_dec ? (r_rdata - CW'(1)) : (r_rdata + CW'(1));
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            S_WALK: begin
                rd_en = (32'(r_lvl) <= VALUE_BITS);
            end
            S_SEL_START: begin
                rd_en = 1'b1;
                rd_addr = AW'(2);
                ring_rd = 1'b1;
            end
            S_SEL: begin
                rd_en = (32'(r_lvl) != VALUE_BITS - 1);
                rd_addr = {sel_node[AW-2:0], 1'b0};
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tree_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= tree_mem[rd_addr];
        end
        r_waddr <= rd_addr;
        if (accept) begin
            ring_mem[ptr_use] <= VALUE_BITS'(i_sample);
        end
        if (ring_rd) begin
            r_ring_q <= ring_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_wlen <= WLEN_RESET;
            r_fill <= '0;
            r_ptr <= '0;
            r_clr <= '0;
            r_lvl <= '0;
            r_o_valid <= 1'b0;
            r_wpend <= 1'b0;
            r_dec <= 1'b0;
            r_emit <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_ptr <= n_ptr;
            r_clr <= n_clr;
            r_lvl <= n_lvl;
            r_o_valid <= n_o_valid;
            r_wpend <= n_wpend;
            r_dec <= n_dec;
            r_emit <= n_emit;
            if (i_cfg_valid && r_fill == '0) begin
                r_wlen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_node <= n_node;
        r_rank <= n_rank;
        r_med <= n_med;
        r_o_median <= n_o_median;
    end

    assign o_cfg_ready = 1'b1;
    assign o_sample_stall = (r_state != S_IDLE);
    assign o_median_valid = r_o_valid;
    assign o_median = r_o_median;

`include "sliding_window_median_assert.svh"

    `SWM_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, rd_en && wr_en, rd_addr != wr_addr)
    `SWM_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, r_state != S_CLEAR, r_fill <= k_eff)
    `SWM_ASSERT_NXT(a_push_waits, i_clk, i_rst_n,
        r_state == S_PUSH && r_o_valid && i_median_stall, r_state == S_PUSH)
    `SWM_ASSERT_IMP(a_sel_after_add, i_clk, i_rst_n, r_state == S_SEL_START, r_emit && !r_dec)

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import swm_pkg::*;

    localparam int MAX_WIN     = 4096;
    localparam int N_RANDOM    = 1700;
    localparam int CALM_ITEMS  = 200;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   has_exp;
        logic [SAMPLE_BITS-1:0] median;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_BITS-1:0]    i_cfg_data;
    logic                   i_sample_valid;
    logic                   o_sample_stall;
    logic [SAMPLE_BITS-1:0] i_sample;
    logic                   o_median_valid;
    logic                   i_median_stall;
    logic [SAMPLE_BITS-1:0] o_median;

    logic [CFG_BITS-1:0]    wlen;
    int                     fill;
    logic [SAMPLE_BITS-1:0] window_q[$];
    logic [SAMPLE_BITS-1:0] exp_medians[$];
    int                     errors;
    int                     n_checked;
    int                     cycles;
    int                     stall_left;
    int                     hold_left;
    bit                     pressure_done;
    bit                     calm;
    t_row                   rows[$];

    sliding_window_median u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample       (i_sample),
        .o_median_valid (o_median_valid),
        .i_median_stall (i_median_stall),
        .o_median       (o_median)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int window_size();
        if (wlen == '0) begin
            return 1;
        end
        if (wlen > MAX_WIN) begin
            return MAX_WIN;
        end
        return int'(wlen);
    endfunction

    // Returns 1 and the lower median once the window is full.
    function automatic bit window_median(input logic [SAMPLE_BITS-1:0] s,
                                         output logic [SAMPLE_BITS-1:0] med);
        logic [SAMPLE_BITS-1:0] sorted[$];
        int                     k;
        k = window_size();
        window_q.push_back(s);
        if (fill < k) begin
            fill++;
        end
        if (window_q.size() < k) begin
            return 1'b0;
        end
        sorted = window_q;
        sorted.sort();
        med = sorted[(k + 1) / 2 - 1];
        void'(window_q.pop_front());
        return 1'b1;
    endfunction

    task automatic write_wlen(input logic [CFG_BITS-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        if (fill == 0) begin
            wlen = v;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_sample(input logic [SAMPLE_BITS-1:0] s, input bit has_exp,
                              input logic [SAMPLE_BITS-1:0] typed);
        logic [SAMPLE_BITS-1:0] med;
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do begin
            @(posedge i_clk);
        end while (o_sample_stall);
        if (window_median(s, med)) begin
            exp_medians.push_back(has_exp ? typed : med);
        end
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_sample_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return SAMPLE_BITS'($urandom_range(0, 15));
            3: return SAMPLE_BITS'($urandom_range(65520, 65535));
            default: return SAMPLE_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic next_stall;
        if (o_median_valid && !i_median_stall) begin
            if (exp_medians.size() == 0) begin
                $display("%0t: unexpected median, expected none, actual %0d", $time, o_median);
                errors++;
            end else begin
                if (o_median !== exp_medians[0]) begin
                    $display("%0t: median mismatch, expected %0d, actual %0d",
                             $time, exp_medians[0], o_median);
                    errors++;
                end
                void'(exp_medians.pop_front());
            end
            n_checked++;
        end
        next_stall = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
        end else if (!pressure_done && n_checked == 150) begin
            pressure_done = 1'b1;
            hold_left = 1500;
            next_stall = 1'b1;
        end else if (calm) begin
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            next_stall = 1'b1;
        end
        i_median_stall <= next_stall;
    end

    initial begin
        errors         = 0;
        n_checked      = 0;
        cycles         = 0;
        stall_left     = 0;
        hold_left      = 0;
        pressure_done  = 1'b0;
        calm           = 1'b0;
        fill           = 0;
        wlen           = WLEN_RESET;
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_data     <= '0;
        i_sample_valid <= 1'b0;
        i_sample       <= '0;
        i_median_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_wlen('0);
        write_wlen('1);
        write_wlen(CFG_BITS'($urandom_range(1, 12)));

        // Twelve equal samples fill the window (at most twelve), so its median is that sample.
        for (int i = 0; i < 12; i++) begin
            rows.push_back('{16'h0000, i == 11, 16'h0000});
        end
        for (int i = 0; i < 12; i++) begin
            rows.push_back('{16'hFFFF, i == 11, 16'hFFFF});
        end
        rows.push_back('{16'hAAAA, 1'b0, 16'h0000});
        rows.push_back('{16'h5555, 1'b0, 16'h0000});
        rows.push_back('{16'h0001, 1'b0, 16'h0000});
        rows.push_back('{16'h8000, 1'b0, 16'h0000});
        foreach (rows[i]) begin
            put_sample(rows[i].sample, rows[i].has_exp, rows[i].median);
            sender_gap();
        end

        // The window is no longer empty, so this write must be ignored.
        i_sample_valid <= 1'b0;
        wait (exp_medians.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        write_wlen(CFG_BITS'($urandom_range(1, 12)));

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - CALM_ITEMS) begin
                calm = 1'b1;
            end
            put_sample(random_sample(), 1'b0, '0);
            sender_gap();
        end
        i_sample_valid <= 1'b0;

        wait (exp_medians.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
